[rtl/core/assert_macros.svh]
// assertion macros used by the rrb_checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// overlapping implication, disabled while in reset
`define RRB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled while in reset
`define RRB_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

// next-cycle implication that also holds through reset
`define RRB_ASSERT_NXT_ALL(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/core/rrb_pkg.sv]
// types, constants and codes for the random ring builder
// no dependencies
`default_nettype none
package rrb_pkg;

  localparam int MAX_ENTRIES = 4096;
  localparam int ADDR_W      = $clog2(MAX_ENTRIES);
  localparam int LEN_W       = ADDR_W + 1;
  localparam int SEED_W      = 64;
  localparam logic [SEED_W-1:0] SEED_RESET = 64'h0123_4567_89AB_CDEF;
  localparam int XS_A = 13;
  localparam int XS_B = 7;
  localparam int XS_C = 17;

  typedef enum logic {
    OP_BUILD = 1'b0,
    OP_READ  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_BUILD_DONE = 2'd0,
    ST_READ_OK    = 2'd1,
    ST_READ_REJ   = 2'd2,
    ST_LEN_REJ    = 2'd3
  } status_t;

  typedef struct packed {
    op_t               op;
    logic [LEN_W-1:0]  ring_length;
    logic [ADDR_W-1:0] entry_index;
  } in_t;

  typedef struct packed {
    logic [ADDR_W-1:0] successor;
    status_t           status;
  } out_t;

  typedef enum logic [3:0] {
    S_IDLE, S_RDCAP, S_RESP, S_FILL, S_DRAW, S_MODW,
    S_RDK, S_RDJ, S_WRK, S_WRJ, S_LINK0, S_LINK, S_LINKEND
  } state_t;

  // next xorshift64 word
  function automatic logic [SEED_W-1:0] xs_next(input logic [SEED_W-1:0] x);
    logic [SEED_W-1:0] a, b;
    a = x ^ (x << XS_A);
    b = a ^ (a >> XS_B);
    return b ^ (b << XS_C);
  endfunction

endpackage
`default_nettype wire

[rtl/core/rrb_ram.sv]
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none
module rrb_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata_r
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end
endmodule
`default_nettype wire

[rtl/core/rrb_mod.sv]
// bit-serial remainder of a 64-bit word by an address-wide divisor
// depends on rrb_pkg
`default_nettype none
module rrb_mod (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  input  wire logic [rrb_pkg::SEED_W-1:0]      dividend,
  input  wire logic [rrb_pkg::ADDR_W-1:0]      divisor,
  output logic                                 done_r,
  output logic [rrb_pkg::ADDR_W-1:0]           rem_r
);
  localparam int CW = $clog2(rrb_pkg::SEED_W);

  logic [rrb_pkg::SEED_W-1:0] dv_r;
  logic [rrb_pkg::ADDR_W-1:0] d_r;
  logic [CW-1:0]              cnt_r;
  logic                       busy_r;
  logic [rrb_pkg::ADDR_W:0]   trial;
  logic [rrb_pkg::ADDR_W:0]   diff;

  assign trial = {rem_r, dv_r[rrb_pkg::SEED_W-1]};
  assign diff  = trial - {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        dv_r   <= dividend;
        d_r    <= divisor;
        rem_r  <= '0;
        cnt_r  <= '1;
      end else if (busy_r) begin
        // remainder stays below the divisor, so it fits the address width
        rem_r <= (trial >= {1'b0, d_r}) ? diff[rrb_pkg::ADDR_W-1:0]
                                        : trial[rrb_pkg::ADDR_W-1:0];
        dv_r  <= dv_r << 1;
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

[rtl/core/random_ring_builder.sv]
// random ring builder: builds one random cycle over table entries and answers lookups
// reads look up the ring memory; builds fill a permutation, shuffle it with one 64-step
// serial remainder per draw, then relink it into the ring memory
// throughput: one transaction at a time, next accepted once the result is in the output
// register; rst_n (synchronous) clears control, ring flag and size, reloads the seed
`default_nettype none
module random_ring_builder (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire rrb_pkg::in_t               in_data,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output rrb_pkg::out_t                   out_data,
  input  wire logic                       cfg_we,
  input  wire logic [rrb_pkg::SEED_W-1:0] cfg_wdata
);
  localparam int AW = rrb_pkg::ADDR_W;
  localparam int LW = rrb_pkg::LEN_W;

  rrb_pkg::state_t state_r, state_nxt;

  // generator, ring bookkeeping
  logic [rrb_pkg::SEED_W-1:0] rng_r;
  logic [LW-1:0]              size_r;
  logic                       built_r;

  // build working registers
  logic [LW-1:0] len_r;
  logic [LW-1:0] cnt_r;
  logic [AW-1:0] k_r, j_r, pk_r, first_r, prev_r;

  // pending result and output register
  logic [AW-1:0]         res_succ_r;
  rrb_pkg::status_t      res_status_r;
  logic                  out_valid_r;
  rrb_pkg::out_t         out_r;

  // memory ports
  logic          perm_we, ring_we;
  logic [AW-1:0] perm_waddr, perm_wdata, perm_raddr, perm_rdata;
  logic [AW-1:0] ring_waddr, ring_wdata, ring_rdata;

  // remainder unit
  logic          mod_start, mod_done;
  logic [AW-1:0] mod_rem;

  logic accept;
  logic len_bad;
  logic rd_ok;

  assign in_ready  = (state_r == rrb_pkg::S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign len_bad = (in_data.ring_length == '0) ||
                   (in_data.ring_length > LW'(rrb_pkg::MAX_ENTRIES));
  assign rd_ok   = built_r && ({1'b0, in_data.entry_index} < size_r);

  rrb_ram #(.WIDTH(AW), .DEPTH(rrb_pkg::MAX_ENTRIES)) u_perm (
    .clk(clk), .we(perm_we), .waddr(perm_waddr), .wdata(perm_wdata),
    .raddr(perm_raddr), .rdata_r(perm_rdata)
  );

  rrb_ram #(.WIDTH(AW), .DEPTH(rrb_pkg::MAX_ENTRIES)) u_ring (
    .clk(clk), .we(ring_we), .waddr(ring_waddr), .wdata(ring_wdata),
    .raddr(in_data.entry_index), .rdata_r(ring_rdata)
  );

  rrb_mod u_mod (
    .clk(clk), .rst_n(rst_n), .start(mod_start),
    .dividend(rrb_pkg::xs_next(rng_r)), .divisor(k_r),
    .done_r(mod_done), .rem_r(mod_rem)
  );

  // next state and memory controls
  always_comb begin
    state_nxt  = state_r;
    perm_we    = 1'b0;
    perm_waddr = cnt_r[AW-1:0];
    perm_wdata = cnt_r[AW-1:0];
    perm_raddr = k_r;
    ring_we    = 1'b0;
    ring_waddr = prev_r;
    ring_wdata = perm_rdata;
    mod_start  = 1'b0;
    case (state_r)
      rrb_pkg::S_IDLE: begin
        if (accept) begin
          if (in_data.op == rrb_pkg::OP_READ) begin
            state_nxt = rrb_pkg::S_RDCAP;
          end else if (len_bad) begin
            state_nxt = rrb_pkg::S_RESP;
          end else begin
            state_nxt = rrb_pkg::S_FILL;
          end
        end
      end
      rrb_pkg::S_RDCAP: state_nxt = rrb_pkg::S_RESP;
      rrb_pkg::S_RESP: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = rrb_pkg::S_IDLE;
        end
      end
      // identity fill
      rrb_pkg::S_FILL: begin
        perm_we = 1'b1;
        if (cnt_r == len_r - 1'b1) begin
          state_nxt = (len_r == LW'(1)) ? rrb_pkg::S_LINK0 : rrb_pkg::S_DRAW;
        end
      end
      // shuffle: draw, remainder, swap perm[k] with perm[j]
      rrb_pkg::S_DRAW: begin
        mod_start = 1'b1;
        state_nxt = rrb_pkg::S_MODW;
      end
      rrb_pkg::S_MODW: begin
        if (mod_done) begin
          state_nxt = rrb_pkg::S_RDK;
        end
      end
      rrb_pkg::S_RDK: begin
        perm_raddr = k_r;
        state_nxt  = rrb_pkg::S_RDJ;
      end
      rrb_pkg::S_RDJ: begin
        perm_raddr = j_r;
        state_nxt  = rrb_pkg::S_WRK;
      end
      rrb_pkg::S_WRK: begin
        perm_we    = 1'b1;
        perm_waddr = k_r;
        perm_wdata = perm_rdata;
        state_nxt  = rrb_pkg::S_WRJ;
      end
      rrb_pkg::S_WRJ: begin
        perm_we    = 1'b1;
        perm_waddr = j_r;
        perm_wdata = pk_r;
        state_nxt  = (k_r == AW'(1)) ? rrb_pkg::S_LINK0 : rrb_pkg::S_DRAW;
      end
      // relink: stream perm reads, write ring[prev] = current
      rrb_pkg::S_LINK0: begin
        perm_raddr = '0;
        state_nxt  = rrb_pkg::S_LINK;
      end
      rrb_pkg::S_LINK: begin
        perm_raddr = cnt_r[AW-1:0];
        ring_we    = (cnt_r != LW'(1));
        if (cnt_r == len_r) begin
          state_nxt = rrb_pkg::S_LINKEND;
        end
      end
      rrb_pkg::S_LINKEND: begin
        // close the cycle: last entry points back at the first
        ring_we    = 1'b1;
        ring_wdata = first_r;
        state_nxt  = rrb_pkg::S_RESP;
      end
      default: state_nxt = rrb_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rrb_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // datapath and bookkeeping
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rng_r       <= rrb_pkg::SEED_RESET;
      size_r      <= '0;
      built_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // seed write reloads the generator, each draw advances it
      if (cfg_we) begin
        rng_r <= cfg_wdata;
      end else if (state_r == rrb_pkg::S_DRAW) begin
        rng_r <= rrb_pkg::xs_next(rng_r);
      end
      // output register: load a finished result, or drain on a handshake
      if (state_r == rrb_pkg::S_RESP && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        rrb_pkg::S_IDLE: begin
          if (accept) begin
            len_r      <= in_data.ring_length;
            cnt_r      <= '0;
            k_r        <= AW'(in_data.ring_length - 1'b1);
            res_succ_r <= '0;
            if (in_data.op == rrb_pkg::OP_READ) begin
              res_status_r <= rd_ok ? rrb_pkg::ST_READ_OK : rrb_pkg::ST_READ_REJ;
            end else if (len_bad) begin
              res_status_r <= rrb_pkg::ST_LEN_REJ;
            end else begin
              res_status_r <= rrb_pkg::ST_BUILD_DONE;
            end
          end
        end
        rrb_pkg::S_RDCAP: begin
          if (res_status_r == rrb_pkg::ST_READ_OK) begin
            res_succ_r <= ring_rdata;
          end
        end
        rrb_pkg::S_RESP: begin
          if (!out_valid_r || out_ready) begin
            out_r.successor  <= res_succ_r;
            out_r.status     <= res_status_r;
          end
        end
        rrb_pkg::S_FILL: begin
          cnt_r <= (cnt_r == len_r - 1'b1) ? LW'(1) : cnt_r + 1'b1;
        end
        rrb_pkg::S_MODW: begin
          if (mod_done) begin
            j_r <= mod_rem;
          end
        end
        rrb_pkg::S_RDJ: pk_r <= perm_rdata;
        rrb_pkg::S_WRJ: k_r <= k_r - 1'b1;
        rrb_pkg::S_LINK0: cnt_r <= LW'(1);
        rrb_pkg::S_LINK: begin
          if (cnt_r == LW'(1)) begin
            first_r <= perm_rdata;
          end
          prev_r <= perm_rdata;
          cnt_r  <= cnt_r + 1'b1;
        end
        rrb_pkg::S_LINKEND: begin
          size_r  <= len_r;
          built_r <= 1'b1;
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

[rtl/core/rrb_checker.sv]
// port-level checker for random_ring_builder, bound to the top level
// depends on rrb_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"
module rrb_checker (
  input wire logic          clk,
  input wire logic          rst_n,
  input wire logic          in_valid,
  input wire logic          in_ready,
  input wire logic          out_valid,
  input wire logic          out_ready,
  input wire rrb_pkg::out_t out_data
);
  `RRB_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  `RRB_ASSERT_NXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(out_data))
  `RRB_ASSERT_IMP(a_succ_zero, clk, rst_n, out_valid && out_data.status != rrb_pkg::ST_READ_OK, out_data.successor == '0)
  `RRB_ASSERT_NXT(a_one_at_a_time, clk, rst_n, in_valid && in_ready, !in_ready)
  `RRB_ASSERT_NXT_ALL(a_reset_idle, clk, !rst_n, !out_valid)
endmodule

bind random_ring_builder rrb_checker u_rrb_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
`default_nettype wire
